/* hw/rtl/pscd_pkg.sv */
// ============================================================================
// pscd_pkg
// Shared types, widths and opcodes of the point set centroid block.
// ============================================================================
`default_nettype none

package pscd_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 16;
    localparam int ADDR_BITS  = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = ADDR_BITS + 1;
    localparam int SUM_BITS   = COORD_BITS + CNT_BITS;
    localparam int DIST_BITS  = 17;
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);

    typedef enum logic [0:0] {
        OP_ADD    = 1'b0,
        OP_FINISH = 1'b1
    } op_t;

    // One command from the front part to the back part.
    typedef struct packed {
        op_t                          op;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVX,
        ST_DIVY,
        ST_RD,
        ST_DIFF,
        ST_SQR,
        ST_ROOT,
        ST_ACC,
        ST_MEAN,
        ST_E2,
        ST_MSQ,
        ST_VROOT,
        ST_VWAIT,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/point_set_centroid_dispersion.sv */
// ============================================================================
// point_set_centroid_dispersion
// Centroid, mean distance and spread of a list of signed Q12.4 points.
// ============================================================================
// Usage: items enter through push/full with operation, point_x, point_y.
// An add item stores the point and updates the coordinate sums; the front
// part takes one item per cycle, while the queue is not full, into a
// four-entry command queue. A finish item makes the back part divide the
// sums by the count on the bit-serial divider, then walk the point memory,
// taking per point one read, a subtract, two squares and a bit-serial
// root. Two more divisions and a final root follow. Adds behind a finish
// wait in the queue and stall push when it fills. A finish with no points
// skips the walk. Each result sits in an output register on the
// empty/pop side; while it is not popped the back part holds the next
// finish. Points past capacity are dropped and flagged. Reset clears the
// count, sums, queue and result-valid flag; the memory is not cleared,
// since only written entries are ever read.
// ============================================================================
`default_nettype none

module point_set_centroid_dispersion
    import pscd_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [0:0]                   operation,
    input  wire logic signed [COORD_BITS-1:0] point_x,
    input  wire logic signed [COORD_BITS-1:0] point_y,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [CNT_BITS-1:0]               point_total,
    output logic signed [COORD_BITS-1:0]      center_x,
    output logic signed [COORD_BITS-1:0]      center_y,
    output logic [DIST_BITS-1:0]              mean_distance,
    output logic [DIST_BITS-1:0]              distance_spread,
    output logic                              dropped_points
);

    cmd_t   q_in, q_out;
    logic   q_full, q_empty, q_pop;
    logic   acc;

    assign q_in.op = op_t'(operation);
    assign q_in.x  = point_x;
    assign q_in.y  = point_y;
    assign full    = q_full;
    assign acc     = push && !q_full;

    pscd_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (q_in),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_out),
        .empty   (q_empty)
    );

    // Back part state.
    state_t                       st_reg, st_next;
    logic [CNT_BITS-1:0]          n_reg;
    logic signed [SUM_BITS-1:0]   xs_reg, ys_reg;
    logic                         ovf_reg;
    logic [ADDR_BITS-1:0]         idx_reg;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [COORD_BITS*2-1:0]      mem_rd_reg;
    logic [COORD_BITS*2-1:0]      point_mem [MAX_POINTS];
    logic [COORD_BITS:0]          dx_reg, dy_reg;
    logic [47:0]                  d2_reg;
    logic [47:0]                  rsum_reg, r2sum_reg;
    logic [47:0]                  mean_reg, e2_reg, var_reg;
    logic                         out_valid_reg;
    logic [CNT_BITS-1:0]          o_n_reg;
    logic signed [COORD_BITS-1:0] o_cx_reg, o_cy_reg;
    logic [DIST_BITS-1:0]         o_mean_reg, o_spr_reg;
    logic                         o_ovf_reg;

    // Division and root units.
    logic        div_start, div_done, sq_start, sq_done;
    logic [47:0] div_a, div_q;
    logic [47:0] sq_a;
    logic [23:0] sq_r;
    logic        div_go_reg, sq_go_reg;

    pscd_divider u_div (
        .clk (clk), .rst_n (rst_n), .start (div_start),
        .dividend (div_a), .divisor (n_reg),
        .done (div_done), .quotient (div_q)
    );

    pscd_sqrt u_sqrt (
        .clk (clk), .rst_n (rst_n), .start (sq_start),
        .radicand (sq_a), .done (sq_done), .root (sq_r)
    );

    logic         is_add, is_fin, can_add;
    logic [SUM_BITS-1:0] xs_abs, ys_abs;
    logic signed [COORD_BITS-1:0] mx, my;
    logic [47:0] msq;

    assign is_add  = !q_empty && (q_out.op == OP_ADD) && (st_reg == ST_IDLE);
    assign is_fin  = !q_empty && (q_out.op == OP_FINISH) && (st_reg == ST_IDLE)
                     && !out_valid_reg;
    assign can_add = (n_reg < CNT_BITS'(MAX_POINTS));
    assign xs_abs  = xs_reg[SUM_BITS-1] ? SUM_BITS'(-xs_reg) : SUM_BITS'(xs_reg);
    assign ys_abs  = ys_reg[SUM_BITS-1] ? SUM_BITS'(-ys_reg) : SUM_BITS'(ys_reg);
    assign mx      = mem_rd_reg[COORD_BITS*2-1:COORD_BITS];
    assign my      = mem_rd_reg[COORD_BITS-1:0];
    assign msq     = mean_reg[23:0] * mean_reg[23:0];

    // Next state and unit starts.
    always_comb
    begin
        st_next   = st_reg;
        q_pop     = 1'b0;
        div_start = 1'b0;
        div_a     = 48'(xs_abs);
        sq_start  = 1'b0;
        sq_a      = d2_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (is_add)
                begin
                    q_pop = 1'b1;
                end
                else if (is_fin)
                begin
                    if (n_reg == '0)
                    begin
                        st_next = ST_OUT;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        st_next   = ST_DIVX;
                    end
                end
            end
            ST_DIVX:
            begin
                if (div_done && !div_go_reg)
                begin
                    div_a     = 48'(ys_abs);
                    div_start = 1'b1;
                    st_next   = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (div_done && !div_go_reg)
                begin
                    st_next = ST_RD;
                end
            end
            ST_RD:   st_next = ST_DIFF;
            ST_DIFF: st_next = ST_SQR;
            ST_SQR:
            begin
                st_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                sq_start = 1'b1;
                st_next  = ST_ACC;
            end
            ST_ACC:
            begin
                if (sq_done && !sq_go_reg)
                begin
                    if (idx_reg == ADDR_BITS'(n_reg - 1'b1))
                    begin
                        div_a     = rsum_reg + 48'(sq_r);
                        div_start = 1'b1;
                        st_next   = ST_MEAN;
                    end
                    else
                    begin
                        st_next = ST_RD;
                    end
                end
            end
            ST_MEAN:
            begin
                if (div_done && !div_go_reg)
                begin
                    div_a     = r2sum_reg;
                    div_start = 1'b1;
                    st_next   = ST_E2;
                end
            end
            ST_E2:
            begin
                if (div_done && !div_go_reg)
                begin
                    st_next = ST_MSQ;
                end
            end
            ST_MSQ:
            begin
                st_next = ST_VROOT;
            end
            ST_VROOT:
            begin
                sq_a     = var_reg;
                sq_start = 1'b1;
                st_next  = ST_VWAIT;
            end
            ST_VWAIT:
            begin
                if (sq_done && !sq_go_reg)
                begin
                    st_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                q_pop   = 1'b1;
                st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // Point memory: written on add, read during the walk.
    always_ff @(posedge clk)
    begin
        if (is_add && can_add)
        begin
            point_mem[n_reg[ADDR_BITS-1:0]] <= {q_out.x, q_out.y};
        end
        mem_rd_reg <= point_mem[idx_reg];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            n_reg         <= '0;
            xs_reg        <= '0;
            ys_reg        <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            div_go_reg    <= 1'b0;
            sq_go_reg     <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            st_reg     <= st_next;
            div_go_reg <= div_start;
            sq_go_reg  <= sq_start;
            if (is_add)
            begin
                if (can_add)
                begin
                    n_reg  <= n_reg + 1'b1;
                    xs_reg <= xs_reg + SUM_BITS'(q_out.x);
                    ys_reg <= ys_reg + SUM_BITS'(q_out.y);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (st_reg == ST_IDLE)
            begin
                idx_reg <= '0;
            end
            else if (st_reg == ST_ACC && sq_done && !sq_go_reg)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (st_reg == ST_OUT)
            begin
                n_reg         <= '0;
                xs_reg        <= '0;
                ys_reg        <= '0;
                ovf_reg       <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers of the walk and final math.
    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            ST_IDLE:
            begin
                rsum_reg  <= '0;
                r2sum_reg <= '0;
                cx_reg    <= '0;
                cy_reg    <= '0;
            end
            ST_DIVX:
            begin
                if (div_done && !div_go_reg)
                begin
                    cx_reg <= xs_reg[SUM_BITS-1] ? -COORD_BITS'(div_q)
                                                 : COORD_BITS'(div_q);
                end
            end
            ST_DIVY:
            begin
                if (div_done && !div_go_reg)
                begin
                    cy_reg <= ys_reg[SUM_BITS-1] ? -COORD_BITS'(div_q)
                                                 : COORD_BITS'(div_q);
                end
            end
            ST_DIFF:
            begin
                dx_reg <= (mx >= cx_reg) ? (COORD_BITS+1)'(mx - cx_reg)
                    : (COORD_BITS+1)'((COORD_BITS+1)'(cx_reg) - (COORD_BITS+1)'(mx));
                dy_reg <= (my >= cy_reg) ? (COORD_BITS+1)'(my - cy_reg)
                    : (COORD_BITS+1)'((COORD_BITS+1)'(cy_reg) - (COORD_BITS+1)'(my));
            end
            ST_SQR:
            begin
                d2_reg <= 48'(dx_reg * dx_reg) + 48'(dy_reg * dy_reg);
            end
            ST_ACC:
            begin
                if (sq_done && !sq_go_reg)
                begin
                    rsum_reg  <= rsum_reg + 48'(sq_r);
                    r2sum_reg <= r2sum_reg + d2_reg;
                end
            end
            ST_MEAN:
            begin
                if (div_done && !div_go_reg)
                begin
                    mean_reg <= div_q;
                end
            end
            ST_E2:
            begin
                if (div_done && !div_go_reg)
                begin
                    e2_reg <= div_q;
                end
            end
            ST_MSQ:
            begin
                var_reg <= (e2_reg > msq) ? (e2_reg - msq) : '0;
            end
            default:
            begin
            end
        endcase
    end

    // Result register on the output side.
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_OUT)
        begin
            o_n_reg    <= n_reg;
            o_ovf_reg  <= ovf_reg;
            o_cx_reg   <= (n_reg == '0) ? '0 : cx_reg;
            o_cy_reg   <= (n_reg == '0) ? '0 : cy_reg;
            o_mean_reg <= (n_reg == '0) ? '0 :
                ((mean_reg > 48'd131071) ? '1 : DIST_BITS'(mean_reg));
            o_spr_reg  <= (n_reg == '0) ? '0 : DIST_BITS'(sq_r);
        end
    end

    assign empty           = !out_valid_reg;
    assign point_total     = o_n_reg;
    assign center_x        = o_cx_reg;
    assign center_y        = o_cy_reg;
    assign mean_distance   = o_mean_reg;
    assign distance_spread = o_spr_reg;
    assign dropped_points  = o_ovf_reg;

    // The stored count never passes capacity.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_BITS'(MAX_POINTS))
        else $error("point count beyond capacity");

    // A new result is only produced once the previous one was taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_OUT) |-> !out_valid_reg || pop)
        else $error("result overwritten");

    // A dropped point sets the overflow flag.
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (is_add && !can_add) |=> ovf_reg)
        else $error("overflow not flagged");

    // An accepted item reaches the queue.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> !q_empty || $past(q_pop))
        else $error("accepted item lost");

endmodule

`default_nettype wire

/* hw/rtl/pscd_cmd_queue.sv */
// ============================================================================
// pscd_cmd_queue
// Short queue of commands between the front and back parts.
// ============================================================================
`default_nettype none

module pscd_cmd_queue
    import pscd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  cmd_t      wr_data,
    output logic      full,
    input  wire logic rd_en,
    output cmd_t      rd_data,
    output logic      empty
);

    cmd_t                 mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wptr_reg, rptr_reg;
    logic [QPTR_BITS:0]   cnt_reg;

    assign full    = (cnt_reg == (QPTR_BITS+1)'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rptr_reg];

    // Storage is written without reset.
    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd_en && !empty)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QPTR_BITS+1)'(wr_en && !full)
                               - (QPTR_BITS+1)'(rd_en && !empty);
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pscd_divider.sv */
// ============================================================================
// pscd_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module pscd_divider
    import pscd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [47:0]         dividend,
    input  wire logic [CNT_BITS-1:0] divisor,
    output logic                     done,
    output logic [47:0]              quotient
);

    logic [47:0]         quo_reg;
    logic [CNT_BITS:0]   rem_reg;
    logic [CNT_BITS-1:0] dvs_reg;
    logic [5:0]          cnt_reg;
    logic                busy_reg;
    logic [CNT_BITS:0]   trial;

    assign trial    = {rem_reg[CNT_BITS-1:0], quo_reg[47]};
    assign quotient = quo_reg;
    assign done     = !busy_reg;

    // One shift and subtract step per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd47;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= trial - {1'b0, dvs_reg};
                quo_reg <= {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[46:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pscd_sqrt.sv */
// ============================================================================
// pscd_sqrt
// Floor square root of a 48-bit value, one result bit per cycle.
// ============================================================================
`default_nettype none

module pscd_sqrt
    import pscd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [47:0] radicand,
    output logic             done,
    output logic [23:0]      root
);

    logic [47:0] val_reg;
    logic [23:0] res_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [47:0] cand;
    logic [47:0] bitv;

    assign bitv = 48'd1 << {cnt_reg, 1'b0};
    assign cand = {res_reg, 24'd0} >> (5'd23 - cnt_reg) | bitv;
    assign root = res_reg;
    assign done = !busy_reg;

    // Decide one root bit per cycle, from the top.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd23;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // cand = (res << (cnt+1)) + 4^cnt; accept when it fits under val.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= radicand;
            res_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (val_reg >= cand)
            begin
                val_reg <= val_reg - cand;
                res_reg <= res_reg | (24'd1 << cnt_reg);
            end
        end
    end

endmodule

`default_nettype wire
